@@ design/dda_pkg.sv @@
`timescale 1ns / 1ps

package dda_pkg;

    localparam int SCREEN_BITS  = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam int COLOUR_BITS  = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 12'd320;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 12'd240;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic {
        REQ_LINE    = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ design/dda_if.sv @@
`timescale 1ns / 1ps

interface dda_cmd_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, red, green, blue,
        output ready
    );
endinterface

interface dda_pix_if #(parameter int COORD_BITS = 12);
    logic                       valid;
    logic                       ready;
    logic signed [COORD_BITS:0] pixel_x;
    logic signed [COORD_BITS:0] pixel_y;
    logic [31:0]                colour_word;
    logic                       on_screen;
    logic                       last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, colour_word, on_screen, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, colour_word, on_screen, last_pixel,
        output ready
    );
endinterface

@@ design/dda_front.sv @@
`timescale 1ns / 1ps

module dda_front #(
    parameter int COORD_BITS = 12,
    parameter int ENTRY_BITS = 5 * COORD_BITS + 3 + dda_pkg::COLOUR_BITS
) (
    dda_cmd_if.sink                i_cmd,
    input  dda_pkg::t_q_stat       i_q_stat,
    output logic                   o_push,
    output logic [ENTRY_BITS-1:0]  o_entry
);
    import dda_pkg::*;

    typedef struct packed {
        t_req                         kind;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0]        mag_x;
        logic [COORD_BITS-1:0]        mag_y;
        logic [COORD_BITS-1:0]        span;
        logic                         neg_x;
        logic                         neg_y;
        logic [COLOUR_BITS-1:0]       colour;
    } t_entry;

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_inv;
    logic [COORD_BITS:0]   dy_inv;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    t_entry                entry;

    // axis differences carry one extra bit so the full range stays exact
    assign dx     = {i_cmd.end_x[COORD_BITS-1], i_cmd.end_x}
                  - {i_cmd.start_x[COORD_BITS-1], i_cmd.start_x};
    assign dy     = {i_cmd.end_y[COORD_BITS-1], i_cmd.end_y}
                  - {i_cmd.start_y[COORD_BITS-1], i_cmd.start_y};
    assign dx_inv = -dx;
    assign dy_inv = -dy;
    assign mag_x  = dx[COORD_BITS] ? dx_inv[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign mag_y  = dy[COORD_BITS] ? dy_inv[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    always_comb begin
        entry.kind    = t_req'(i_cmd.req_type);
        entry.start_x = i_cmd.start_x;
        entry.start_y = i_cmd.start_y;
        entry.mag_x   = mag_x;
        entry.mag_y   = mag_y;
        entry.span    = (mag_x > mag_y) ? mag_x : mag_y;
        entry.neg_x   = dx[COORD_BITS];
        entry.neg_y   = dy[COORD_BITS];
        entry.colour  = {ALPHA_OPAQUE, i_cmd.red, i_cmd.green, i_cmd.blue};
    end

    assign i_cmd.ready = !i_q_stat.full;
    assign o_push      = i_cmd.valid && !i_q_stat.full;
    assign o_entry     = entry;

endmodule

@@ design/dda_queue.sv @@
`timescale 1ns / 1ps

module dda_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output dda_pkg::t_q_stat  o_stat
);
    import dda_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push;
    logic                do_pop;
    t_q_stat             stat;

    assign stat.full  = (r_count == FULL_CNT);
    assign stat.empty = (r_count == '0);
    assign do_push    = i_push && !stat.full;
    assign do_pop     = i_pop && !stat.empty;
    assign o_stat     = stat;
    assign o_data     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/dda_back.sv @@
`timescale 1ns / 1ps

module dda_back #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int ENTRY_BITS = 5 * COORD_BITS + 3 + dda_pkg::COLOUR_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [dda_pkg::SCREEN_BITS-1:0]    i_cfg_data,
    input  logic [ENTRY_BITS-1:0]              i_entry,
    input  dda_pkg::t_q_stat                   i_q_stat,
    output logic                               o_pop,
    dda_pix_if.source                          o_pix
);
    import dda_pkg::*;

    localparam int POS_BITS  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS = FRAC_BITS + 2;
    localparam int QUO_BITS  = FRAC_BITS + 1;
    localparam int NUM_BITS  = COORD_BITS + FRAC_BITS + 1;
    localparam int CNT_BITS  = $clog2(QUO_BITS);
    localparam int OUT_BITS  = COORD_BITS + 1;
    localparam int CMP_BITS  = (OUT_BITS > SCREEN_BITS) ? OUT_BITS : SCREEN_BITS;
    localparam logic [CNT_BITS-1:0] CNT_LOAD = CNT_BITS'(QUO_BITS - 1);
    localparam logic [POS_BITS:0]   HALF     = (POS_BITS + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [POS_BITS:0]   HALF_M1  = HALF - 1'b1;

    typedef struct packed {
        t_req                         kind;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0]        mag_x;
        logic [COORD_BITS-1:0]        mag_y;
        logic [COORD_BITS-1:0]        span;
        logic                         neg_x;
        logic                         neg_y;
        logic [COLOUR_BITS-1:0]       colour;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                       r_state;
    logic [CNT_BITS-1:0]          r_cnt;
    logic [COORD_BITS-1:0]        r_span;
    logic [COORD_BITS-1:0]        r_rem_x;
    logic [COORD_BITS-1:0]        r_rem_y;
    logic [QUO_BITS-1:0]          r_quo_x;
    logic [QUO_BITS-1:0]          r_quo_y;
    logic                         r_neg_x;
    logic                         r_neg_y;
    logic signed [POS_BITS-1:0]   r_pos_x;
    logic signed [POS_BITS-1:0]   r_pos_y;
    logic signed [STEP_BITS-1:0]  r_step_x;
    logic signed [STEP_BITS-1:0]  r_step_y;
    logic [COORD_BITS-1:0]        r_steps_left;
    logic [COLOUR_BITS-1:0]       r_colour;
    logic [SCREEN_BITS-1:0]       r_scr_w;
    logic [SCREEN_BITS-1:0]       r_scr_h;
    logic                         r_out_valid;
    logic [OUT_BITS-1:0]          r_out_x;
    logic [OUT_BITS-1:0]          r_out_y;
    logic [COLOUR_BITS-1:0]       r_out_colour;
    logic                         r_out_on;
    logic                         r_out_last;

    t_entry                       head;
    logic                         head_valid;
    logic                         active;
    logic                         out_free;
    logic                         load_line;
    logic                         emit;
    logic [NUM_BITS-1:0]          num_x;
    logic [NUM_BITS-1:0]          num_y;
    logic [COORD_BITS:0]          trial_x;
    logic [COORD_BITS:0]          trial_y;
    logic [COORD_BITS:0]          diff_x;
    logic [COORD_BITS:0]          diff_y;
    logic                         ge_x;
    logic                         ge_y;
    logic signed [STEP_BITS-1:0]  fin_step_x;
    logic signed [STEP_BITS-1:0]  fin_step_y;
    logic [POS_BITS:0]            sum_x;
    logic [POS_BITS:0]            sum_y;
    logic [OUT_BITS-1:0]          px;
    logic [OUT_BITS-1:0]          py;
    logic                         on;

    assign head       = t_entry'(i_entry);
    assign head_valid = !i_q_stat.empty;
    assign active     = (r_steps_left != '0);
    assign out_free   = !r_out_valid || o_pix.ready;
    assign load_line  = (r_state == ST_IDLE) && head_valid && (head.kind == REQ_LINE);
    assign emit       = (r_state == ST_IDLE) && head_valid && (head.kind == REQ_ADVANCE)
                      && active && out_free;

    // an advance with no line running is dropped without waiting for the output
    always_comb begin
        o_pop = 1'b0;
        if ((r_state == ST_IDLE) && head_valid) begin
            if (head.kind == REQ_LINE || !active) begin
                o_pop = 1'b1;
            end else begin
                o_pop = out_free;
            end
        end
    end

    // rounded numerator: (|d| << frac) + span/2
    assign num_x = {1'b0, head.mag_x, {FRAC_BITS{1'b0}}} + NUM_BITS'(head.span >> 1);
    assign num_y = {1'b0, head.mag_y, {FRAC_BITS{1'b0}}} + NUM_BITS'(head.span >> 1);

    // restoring division, one quotient bit per cycle per axis
    assign trial_x = {r_rem_x, r_quo_x[QUO_BITS-1]};
    assign trial_y = {r_rem_y, r_quo_y[QUO_BITS-1]};
    assign diff_x  = trial_x - {1'b0, r_span};
    assign diff_y  = trial_y - {1'b0, r_span};
    assign ge_x    = (trial_x >= {1'b0, r_span});
    assign ge_y    = (trial_y >= {1'b0, r_span});

    assign fin_step_x = r_neg_x ? -$signed({1'b0, r_quo_x}) : $signed({1'b0, r_quo_x});
    assign fin_step_y = r_neg_y ? -$signed({1'b0, r_quo_y}) : $signed({1'b0, r_quo_y});

    // halves away from zero: add half, or half minus one below zero, then floor
    assign sum_x = {r_pos_x[POS_BITS-1], r_pos_x}
                 + (r_pos_x[POS_BITS-1] ? HALF_M1 : HALF);
    assign sum_y = {r_pos_y[POS_BITS-1], r_pos_y}
                 + (r_pos_y[POS_BITS-1] ? HALF_M1 : HALF);
    assign px    = sum_x[FRAC_BITS +: OUT_BITS];
    assign py    = sum_y[FRAC_BITS +: OUT_BITS];
    assign on    = !px[OUT_BITS-1] && !py[OUT_BITS-1]
                 && (CMP_BITS'(px) < CMP_BITS'(r_scr_w))
                 && (CMP_BITS'(py) < CMP_BITS'(r_scr_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCREEN_WIDTH_RST;
            r_scr_h <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SCREEN_WIDTH) begin
                r_scr_w <= i_cfg_data;
            end
            if (i_cfg_idx == REG_SCREEN_HEIGHT) begin
                r_scr_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_steps_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (load_line) begin
                        r_pos_x      <= {head.start_x[COORD_BITS-1], head.start_x,
                                         {FRAC_BITS{1'b0}}};
                        r_pos_y      <= {head.start_y[COORD_BITS-1], head.start_y,
                                         {FRAC_BITS{1'b0}}};
                        r_colour     <= head.colour;
                        r_span       <= head.span;
                        r_neg_x      <= head.neg_x;
                        r_neg_y      <= head.neg_y;
                        r_rem_x      <= num_x[NUM_BITS-1 -: COORD_BITS];
                        r_rem_y      <= num_y[NUM_BITS-1 -: COORD_BITS];
                        r_quo_x      <= num_x[QUO_BITS-1:0];
                        r_quo_y      <= num_y[QUO_BITS-1:0];
                        r_cnt        <= CNT_LOAD;
                        r_steps_left <= '0;
                        if (head.span != '0) begin
                            r_state <= ST_DIV;
                        end
                    end
                    if (emit) begin
                        r_pos_x      <= r_pos_x + POS_BITS'(r_step_x);
                        r_pos_y      <= r_pos_y + POS_BITS'(r_step_y);
                        r_steps_left <= r_steps_left - 1'b1;
                    end
                end
                ST_DIV: begin
                    r_rem_x <= ge_x ? diff_x[COORD_BITS-1:0] : trial_x[COORD_BITS-1:0];
                    r_rem_y <= ge_y ? diff_y[COORD_BITS-1:0] : trial_y[COORD_BITS-1:0];
                    r_quo_x <= {r_quo_x[QUO_BITS-2:0], ge_x};
                    r_quo_y <= {r_quo_y[QUO_BITS-2:0], ge_y};
                    if (r_cnt == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_FIN: begin
                    r_step_x     <= fin_step_x;
                    r_step_y     <= fin_step_y;
                    r_steps_left <= r_span;
                    r_state      <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (emit) begin
                r_out_valid  <= 1'b1;
                r_out_x      <= px;
                r_out_y      <= py;
                r_out_colour <= r_colour;
                r_out_on     <= on;
                r_out_last   <= (r_steps_left == COORD_BITS'(1));
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_out_x;
    assign o_pix.pixel_y     = r_out_y;
    assign o_pix.colour_word = r_out_colour;
    assign o_pix.on_screen   = r_out_on;
    assign o_pix.last_pixel  = r_out_last;

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem_x < r_span) && (r_rem_y < r_span))
        else $error("divider remainder not below step count");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_line && head.span != '0) |=> ##QUO_BITS (r_state == ST_FIN))
        else $error("step division took the wrong number of cycles");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_steps_left == COORD_BITS'(1)) |=> (r_steps_left == '0))
        else $error("line still running after its last pixel");

    a_fin_arms_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_steps_left != '0) && (r_state == ST_IDLE))
        else $error("line setup finished without arming the step count");

endmodule

@@ design/dda_line_rasterizer_top.sv @@
`timescale 1ns / 1ps

// dda line rasteriser
// i_cmd takes one word per request: req_type 0 loads a line (endpoints and
// colour), req_type 1 asks for the next pixel of the current line. o_pix
// gives one word per pixel: coordinates, opaque argb colour, on-screen flag
// and a flag on the last pixel. The end point itself is never drawn.
// A line command is set up once it reaches the head of the two-word command
// queue; the two step divisions run side by side, one quotient bit per cycle,
// and hold later requests back. An advance loads its pixel word into the o_pix
// output register at the edge it leaves the queue, and back-to-back advances
// run at one pixel per clock while o_pix is not stalled. Screen size is written
// through i_cfg_we / i_cfg_idx / i_cfg_data only while idle; the user must keep
// to this, as the block itself does not enforce it. Reset clears the queue,
// drops any line and restores a 320 x 240 screen. When o_pix is stalled the
// output word holds; advances then back up into the queue and i_cmd.ready
// falls once it is full. Line commands and advances with no line running
// produce no output word.
module dda_line_rasterizer_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [dda_pkg::SCREEN_BITS-1:0]   i_cfg_data,
    dda_cmd_if.sink                           i_cmd,
    dda_pix_if.source                         o_pix
);
    import dda_pkg::*;

    localparam int ENTRY_BITS = 5 * COORD_BITS + 3 + COLOUR_BITS;

    t_q_stat               q_stat;
    logic                  push;
    logic                  pop;
    logic [ENTRY_BITS-1:0] push_data;
    logic [ENTRY_BITS-1:0] head_data;

    dda_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .i_cmd    (i_cmd),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_data)
    );

    dda_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_stat  (q_stat)
    );

    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_entry    (head_data),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_pix      (o_pix)
    );

endmodule

@@ tb/dda_line_rasterizer_checker.sv @@
`timescale 1ns / 1ps

module dda_line_rasterizer_checker #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [dda_pkg::SCREEN_BITS-1:0]  i_cfg_data,
    dda_cmd_if                               i_cmd,
    dda_pix_if                               i_pix,
    output int                               o_errors,
    output int                               o_pending
);
    import dda_pkg::*;

    localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;

    typedef struct packed {
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y;
        logic [COLOUR_BITS-1:0]     argb;
        logic                       visible;
        logic                       last_px;
    } t_pixel;

    // own copy of the line state and screen size
    logic signed [POS_W-1:0]  pos_x, pos_y;
    logic signed [STEP_W-1:0] inc_x, inc_y;
    logic [COORD_BITS:0]      pixels_left;
    logic [COLOUR_BITS-1:0]   line_argb;
    logic                     drawing;
    logic [SCREEN_BITS-1:0]   scr_w, scr_h;

    t_pixel expected_pixels[$];

    // axis difference over step count, halves away from zero
    function automatic longint step_of(input longint diff, input longint count);
        longint q;
        q = (((diff < 0) ? -diff : diff) * (longint'(1) << FRAC_BITS) + count / 2) / count;
        return (diff < 0) ? -q : q;
    endfunction

    function automatic longint pixel_of(input longint pos);
        longint q;
        q = (((pos < 0) ? -pos : pos) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (pos < 0) ? -q : q;
    endfunction

    task automatic check_field(input string name, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        longint sx, sy, dx, dy, count, px, py;
        t_pixel want;
        if (!i_rst_n) begin
            pos_x       = '0;
            pos_y       = '0;
            inc_x       = '0;
            inc_y       = '0;
            pixels_left = '0;
            line_argb   = '0;
            drawing     = 1'b0;
            scr_w       = SCREEN_WIDTH_RST;
            scr_h       = SCREEN_HEIGHT_RST;
            expected_pixels.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel word with none expected: x %0d y %0d",
                           i_pix.pixel_x, i_pix.pixel_y);
                    o_errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", want.x, i_pix.pixel_x);
                    check_field("pixel_y", want.y, i_pix.pixel_y);
                    check_field("colour_word", want.argb, i_pix.colour_word);
                    check_field("on_screen", want.visible, i_pix.on_screen);
                    check_field("last_pixel", want.last_px, i_pix.last_pixel);
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SCREEN_WIDTH:  scr_w = i_cfg_data;
                    REG_SCREEN_HEIGHT: scr_h = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.req_type == REQ_LINE) begin
                    sx        = i_cmd.start_x;
                    sy        = i_cmd.start_y;
                    dx        = longint'(i_cmd.end_x) - sx;
                    dy        = longint'(i_cmd.end_y) - sy;
                    count     = ((dx < 0) ? -dx : dx);
                    if (((dy < 0) ? -dy : dy) > count)
                        count = (dy < 0) ? -dy : dy;
                    line_argb = {ALPHA_OPAQUE, i_cmd.red, i_cmd.green, i_cmd.blue};
                    pos_x     = POS_W'(sx * (longint'(1) << FRAC_BITS));
                    pos_y     = POS_W'(sy * (longint'(1) << FRAC_BITS));
                    if (count == 0) begin
                        inc_x       = '0;
                        inc_y       = '0;
                        pixels_left = '0;
                        drawing     = 1'b0;
                    end else begin
                        inc_x       = STEP_W'(step_of(dx, count));
                        inc_y       = STEP_W'(step_of(dy, count));
                        pixels_left = (COORD_BITS + 1)'(count);
                        drawing     = 1'b1;
                    end
                end else if (!drawing || pixels_left == 0) begin
                    // advance with no line running is dropped
                    drawing = 1'b0;
                end else begin
                    px           = pixel_of(pos_x);
                    py           = pixel_of(pos_y);
                    want.x       = (COORD_BITS + 1)'(px);
                    want.y       = (COORD_BITS + 1)'(py);
                    want.argb    = line_argb;
                    want.visible = px >= 0 && py >= 0 && px < longint'(scr_w)
                                   && py < longint'(scr_h);
                    want.last_px = pixels_left == 1;
                    expected_pixels.insert(expected_pixels.size(), want);
                    pos_x        = pos_x + inc_x;
                    pos_y        = pos_y + inc_y;
                    pixels_left  = pixels_left - 1'b1;
                    if (pixels_left == 0)
                        drawing = 1'b0;
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

@@ tb/dda_line_rasterizer_top_tb.sv @@
`timescale 1ns / 1ps

module dda_line_rasterizer_top_tb;
    import dda_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_WORDS   = 450;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [SCREEN_BITS-1:0]  cfg_data;

    int errors, pending;
    int send_idle_pct, stall_pct, hold_left;
    int scr_w, scr_h;
    int drawn_words;

    dda_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();
    dda_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

    dda_line_rasterizer_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_cmd     (cmd_bus),
        .o_pix     (pix_bus)
    );

    dda_line_rasterizer_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pixel_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_cmd     (cmd_bus),
        .i_pix     (pix_bus),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // pixel side: random stalls, or a long hold-off while hold_left runs down
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pix_bus.ready <= 1'b0;
            hold_left--;
        end else begin
            pix_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int clamp_coord(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    task automatic push_word(input t_req kind, input int sx, input int sy, input int ex,
                             input int ey, input int r, input int g, input int b);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        repeat (gap) begin
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_bus.valid    <= 1'b1;
        cmd_bus.req_type <= kind;
        cmd_bus.start_x  <= sx[COORD_BITS-1:0];
        cmd_bus.start_y  <= sy[COORD_BITS-1:0];
        cmd_bus.end_x    <= ex[COORD_BITS-1:0];
        cmd_bus.end_y    <= ey[COORD_BITS-1:0];
        cmd_bus.red      <= r[7:0];
        cmd_bus.green    <= g[7:0];
        cmd_bus.blue     <= b[7:0];
        @(posedge i_clk);
        while (!cmd_bus.ready)
            @(posedge i_clk);
    endtask

    // coordinates and colour ride along on an advance but mean nothing
    task automatic advance_once();
        push_word(REQ_ADVANCE, $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255));
    endtask

    task automatic drain();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic set_screen(input int w, input int h);
        drain();
        // a line setup may still be busy with nothing left to show for it
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_SCREEN_WIDTH;
        cfg_data <= w[SCREEN_BITS-1:0];
        @(negedge i_clk);
        cfg_idx  <= REG_SCREEN_HEIGHT;
        cfg_data <= h[SCREEN_BITS-1:0];
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    task automatic random_line();
        int mode, sx, sy, ex, ey, dx, dy, n, steps, span_x, span_y;
        mode = $urandom_range(99);
        if (mode < 45) begin
            // around the visible area
            span_x = (scr_w < 2040) ? scr_w : 2040;
            span_y = (scr_h < 2040) ? scr_h : 2040;
            sx = int'($urandom_range(span_x + 16)) - 8;
            sy = int'($urandom_range(span_y + 16)) - 8;
            ex = clamp_coord(sx + int'($urandom_range(24)) - 12);
            ey = clamp_coord(sy + int'($urandom_range(24)) - 12);
        end else if (mode < 75) begin
            sx = int'($urandom_range(4095)) - 2048;
            sy = int'($urandom_range(4095)) - 2048;
            ex = clamp_coord(sx + int'($urandom_range(24)) - 12);
            ey = clamp_coord(sy + int'($urandom_range(24)) - 12);
        end else if (mode < 88) begin
            sx = int'($urandom_range(4095)) - 2048;
            sy = int'($urandom_range(4095)) - 2048;
            ex = int'($urandom_range(4095)) - 2048;
            ey = int'($urandom_range(4095)) - 2048;
        end else begin
            sx = int'($urandom_range(4095)) - 2048;
            sy = int'($urandom_range(4095)) - 2048;
            ex = clamp_coord(sx + int'($urandom_range(400)) - 200);
            ey = clamp_coord(sy + int'($urandom_range(400)) - 200);
        end
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;
        n  = (dx > dy) ? dx : dy;
        if (mode >= 75 && mode < 88)
            steps = $urandom_range(8);
        else if ($urandom_range(9) == 0)
            steps = $urandom_range(n);
        else if ($urandom_range(3) == 0)
            steps = n + $urandom_range(1, 2);
        else
            steps = n;
        push_word(REQ_LINE, sx, sy, ex, ey, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255));
        repeat (steps) advance_once();
        drawn_words += 1 + ((steps < n) ? steps : n);
    endtask

    initial begin
        int idle_plan[4];
        int stall_plan[4];
        int target;
        idle_plan  = '{0, 66, 0, 15};
        stall_plan = '{0, 0, 66, 15};

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = REG_SCREEN_WIDTH;
        cfg_data         = '0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.req_type = REQ_LINE;
        cmd_bus.start_x  = '0;
        cmd_bus.start_y  = '0;
        cmd_bus.end_x    = '0;
        cmd_bus.end_y    = '0;
        cmd_bus.red      = '0;
        cmd_bus.green    = '0;
        cmd_bus.blue     = '0;
        pix_bus.ready    = 1'b0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_left        = 0;
        scr_w            = 320;
        scr_h            = 240;
        drawn_words      = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on the reset screen size
        advance_once();
        push_word(REQ_LINE, 0, 0, 0, 0, 0, 0, 0);
        advance_once();
        push_word(REQ_LINE, -2048, -2048, 2047, 2047, 255, 255, 255);
        repeat (3) advance_once();
        push_word(REQ_LINE, 2047, -2048, -2048, 2047, 'h5a, 'ha5, 'h0f);
        repeat (2) advance_once();
        // walks across the bottom right corner of the screen
        push_word(REQ_LINE, 317, 237, 321, 241, 'hf0, 'h0f, 'h81);
        repeat (5) advance_once();
        // half-pixel steps rounding away from zero
        push_word(REQ_LINE, 0, 0, -4, -2, 'h12, 'h34, 'h56);
        repeat (4) advance_once();
        push_word(REQ_LINE, 10, 10, 20, 13, 1, 2, 3);
        advance_once();
        push_word(REQ_LINE, -1, -1, 1, 0, 'h80, 'h40, 'h20);
        repeat (2) advance_once();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_screen(2048, 1);
                1: set_screen(1, 2048);
                2: set_screen(0, $urandom_range(1, 2048));
                default: set_screen($urandom_range(1, 2048), $urandom_range(1, 2048));
            endcase
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            // long hold-off with words still coming so the queue fills up
            if (p == 0)
                hold_left = 300;
            target = drawn_words + PHASE_WORDS;
            while (drawn_words < target) begin
                random_line();
                if ($urandom_range(29) == 0)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
